@@ hw/rtl/signed_divider_quot_rem_top_defines.svh @@
// assertion helpers for the divider
`ifndef SIGNED_DIVIDER_QUOT_REM_TOP_DEFINES_SVH
`define SIGNED_DIVIDER_QUOT_REM_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SDQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sdq_pkg.sv @@
package sdq_pkg;

  localparam int unsigned DATA_W        = 64;
  localparam int unsigned NARROW_W      = 32;
  localparam int unsigned DEFAULT_WIDTH = 64;

  typedef enum logic {
    OP_DIV32 = 1'b0,
    OP_DIV64 = 1'b1
  } sdq_op_e;

  // flags that ride alongside each item down the cell chain
  typedef struct packed {
    logic valid;
    logic narrow;
    logic neg_q;
    logic neg_r;
    logic div_zero;
  } sdq_ctrl_t;

endpackage

@@ hw/rtl/sdq_prep.sv @@
module sdq_prep import sdq_pkg::*; #(
  parameter int unsigned WIDTH = DEFAULT_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic                opcode_i,
  input  logic [DATA_W-1:0]   dividend_i,
  input  logic [DATA_W-1:0]   divisor_i,
  output sdq_ctrl_t           ctrl_o,
  output logic [WIDTH-1:0]    rem_o,
  output logic [WIDTH-1:0]    quo_o,
  output logic [WIDTH-1:0]    dsr_o
);

  localparam int unsigned NW = (WIDTH < NARROW_W) ? WIDTH : NARROW_W;
  localparam int unsigned SH = WIDTH - NW;

  logic             narrow;
  logic [WIDTH-1:0] a_w, b_w, a_s, b_s, mag_a, mag_b;
  sdq_ctrl_t        ctrl_d, ctrl_q;
  logic [WIDTH-1:0] mag_a_q, mag_b_q;

  assign narrow = (opcode_i == OP_DIV32);
  assign a_w    = dividend_i[WIDTH-1:0];
  assign b_w    = divisor_i[WIDTH-1:0];

  always_comb begin
    // narrow mode: sign-extend from the low NW bits
    a_s   = narrow ? WIDTH'($signed(a_w << SH) >>> SH) : a_w;
    b_s   = narrow ? WIDTH'($signed(b_w << SH) >>> SH) : b_w;
    mag_a = a_s[WIDTH-1] ? WIDTH'(-a_s) : a_s;
    mag_b = b_s[WIDTH-1] ? WIDTH'(-b_s) : b_s;

    ctrl_d.valid    = valid_i;
    ctrl_d.narrow   = narrow;
    ctrl_d.neg_q    = a_s[WIDTH-1] ^ b_s[WIDTH-1];
    ctrl_d.neg_r    = a_s[WIDTH-1];
    ctrl_d.div_zero = (b_s == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= mag_a;
      mag_b_q <= mag_b;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = '0;
  assign quo_o  = mag_a_q;
  assign dsr_o  = mag_b_q;

endmodule

@@ hw/rtl/sdq_cell.sv @@
module sdq_cell import sdq_pkg::*; #(
  parameter int unsigned WIDTH = DEFAULT_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  sdq_ctrl_t        ctrl_i,
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] quo_i,
  input  logic [WIDTH-1:0] dsr_i,
  output sdq_ctrl_t        ctrl_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] quo_o,
  output logic [WIDTH-1:0] dsr_o
);

  logic [WIDTH-1:0] rem_sh;
  logic [WIDTH:0]   diff;
  logic             fits;
  sdq_ctrl_t        ctrl_q;
  logic [WIDTH-1:0] rem_q, quo_q, dsr_q;

  // one restoring step: bring down the next dividend bit, try the subtract
  assign rem_sh = {rem_i[WIDTH-2:0], quo_i[WIDTH-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, dsr_i};
  assign fits   = ~diff[WIDTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= fits ? diff[WIDTH-1:0] : rem_sh;
      quo_q <= {quo_i[WIDTH-2:0], fits};
      dsr_q <= dsr_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;
  assign dsr_o  = dsr_q;

endmodule

@@ hw/rtl/sdq_post.sv @@
module sdq_post import sdq_pkg::*; #(
  parameter int unsigned WIDTH = DEFAULT_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  sdq_ctrl_t         ctrl_i,
  input  logic [WIDTH-1:0]  rem_i,
  input  logic [WIDTH-1:0]  quo_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] quotient_o,
  output logic [DATA_W-1:0] remainder_o
);

  localparam int unsigned NW = (WIDTH < NARROW_W) ? WIDTH : NARROW_W;
  localparam int unsigned SH = WIDTH - NW;

  logic [WIDTH-1:0]  q_w, r_w, q_n, r_n;
  logic [DATA_W-1:0] quotient_d, remainder_d;
  logic              valid_q;
  logic [DATA_W-1:0] quotient_q, remainder_q;

  always_comb begin
    q_w = ctrl_i.neg_q ? WIDTH'(-quo_i) : quo_i;
    r_w = ctrl_i.neg_r ? WIDTH'(-rem_i) : rem_i;
    // wrap to the narrow width, then sign-extend
    q_n = ctrl_i.narrow ? WIDTH'($signed(q_w << SH) >>> SH) : q_w;
    r_n = ctrl_i.narrow ? WIDTH'($signed(r_w << SH) >>> SH) : r_w;
    quotient_d  = ctrl_i.div_zero ? '0 : DATA_W'($signed(q_n));
    remainder_d = ctrl_i.div_zero ? '0 : DATA_W'($signed(r_n));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quotient_q  <= quotient_d;
      remainder_q <= remainder_d;
    end
  end

  assign valid_o     = valid_q;
  assign quotient_o  = quotient_q;
  assign remainder_o = remainder_q;

endmodule

@@ hw/rtl/signed_divider_quot_rem_top.sv @@
// channel   dir  tdata (low bit up)             tuser
// s_axis    in   dividend[63:0], divisor[127:64]  opcode (0 = 32-bit, 1 = WIDTH-bit)
// m_axis    out  quotient[63:0], remainder[127:64] -
//
// one transaction accepted per cycle while m_axis is not stalled, results in order
// the chain is a sign/magnitude stage, WIDTH restoring cells, an output stage
// a stall on m_axis freezes the whole chain; s_axis_tready_o drops with it
// reset clears the valid flags of every stage, payload registers are left as they are
`include "signed_divider_quot_rem_top_defines.svh"

module signed_divider_quot_rem_top import sdq_pkg::*; #(
  parameter int unsigned WIDTH = DEFAULT_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [2*DATA_W-1:0] s_axis_tdata_i,  // dividend, divisor
  input  logic                s_axis_tuser_i,  // opcode
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [2*DATA_W-1:0] m_axis_tdata_o   // quotient, remainder
);

  logic              en;
  sdq_ctrl_t         ctrl [WIDTH+1];
  logic [WIDTH-1:0]  rem  [WIDTH+1];
  logic [WIDTH-1:0]  quo  [WIDTH+1];
  logic [WIDTH-1:0]  dsr  [WIDTH+1];
  logic [DATA_W-1:0] quotient, remainder;

  assign en              = ~m_axis_tvalid_o | m_axis_tready_i;
  assign s_axis_tready_o = en;

  sdq_prep #(.WIDTH(WIDTH)) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid_i),
    .opcode_i   (s_axis_tuser_i),
    .dividend_i (s_axis_tdata_i[DATA_W-1:0]),
    .divisor_i  (s_axis_tdata_i[2*DATA_W-1:DATA_W]),
    .ctrl_o     (ctrl[0]),
    .rem_o      (rem[0]),
    .quo_o      (quo[0]),
    .dsr_o      (dsr[0])
  );

  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    sdq_cell #(.WIDTH(WIDTH)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl[k]),
      .rem_i  (rem[k]),
      .quo_i  (quo[k]),
      .dsr_i  (dsr[k]),
      .ctrl_o (ctrl[k+1]),
      .rem_o  (rem[k+1]),
      .quo_o  (quo[k+1]),
      .dsr_o  (dsr[k+1])
    );
  end

  sdq_post #(.WIDTH(WIDTH)) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctrl_i      (ctrl[WIDTH]),
    .rem_i       (rem[WIDTH]),
    .quo_i       (quo[WIDTH]),
    .valid_o     (m_axis_tvalid_o),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  assign m_axis_tdata_o = {remainder, quotient};

  `SDQ_ASSERT_IMPL(a_rem_below_divisor,
    ctrl[WIDTH].valid && !ctrl[WIDTH].div_zero, rem[WIDTH] < dsr[WIDTH],
    "partial remainder not below divisor at end of chain")

  `SDQ_ASSERT_NEXT(a_last_cell_reaches_output,
    ctrl[WIDTH].valid && en, m_axis_tvalid_o,
    "finished item did not reach the output register")

  `SDQ_ASSERT_NEXT(a_zero_divisor_result,
    ctrl[WIDTH].valid && ctrl[WIDTH].div_zero && en, m_axis_tdata_o == '0,
    "zero divisor gave a nonzero result")

endmodule

@@ dv/signed_divider_quot_rem_checker.sv @@
`timescale 1ns / 100ps

module signed_divider_quot_rem_checker import sdq_pkg::*; #(
  parameter int unsigned WIDTH = DEFAULT_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [2*DATA_W-1:0] s_axis_tdata_i,  // dividend, divisor
  input  logic                s_axis_tuser_i,  // opcode
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [2*DATA_W-1:0] m_axis_tdata_i,  // quotient, remainder
  output int                  err_cnt_o,
  output int                  pending_o
);

  localparam int unsigned NARROW_BITS = (WIDTH < NARROW_W) ? WIDTH : NARROW_W;

  typedef struct packed {
    logic [DATA_W-1:0] quot;
    logic [DATA_W-1:0] rem;
  } quot_rem_t;

  quot_rem_t expected_quot_rem_q[$];
  int        n_errors  = 0;
  int        n_waiting = 0;

  assign err_cnt_o = n_errors;
  assign pending_o = n_waiting;

  // low w bits of x, sign-extended to the full data width
  function automatic logic [DATA_W-1:0] sign_fill(input logic [DATA_W-1:0] x,
                                                 input int unsigned w);
    logic [DATA_W-1:0] mask;
    if (w >= DATA_W) return x;
    mask = ({{(DATA_W-1){1'b0}}, 1'b1} << w) - 1'b1;
    x = x & mask;
    if (x[w-1]) x = x | ~mask;
    return x;
  endfunction

  function automatic quot_rem_t divide_truncating(input sdq_op_e op,
                                                  input logic [DATA_W-1:0] dvd,
                                                  input logic [DATA_W-1:0] dvs);
    int unsigned       w;
    logic [DATA_W-1:0] a, b, mag_a, mag_b, mag_q, mag_r, q, r;
    logic              neg_a, neg_b;
    quot_rem_t         res;
    w = (op == OP_DIV64) ? WIDTH : NARROW_BITS;
    a = sign_fill(dvd, w);
    b = sign_fill(dvs, w);
    res.quot = '0;
    res.rem  = '0;
    if (b == '0) return res;
    neg_a = a[DATA_W-1];
    neg_b = b[DATA_W-1];
    mag_a = neg_a ? ('0 - a) : a;
    mag_b = neg_b ? ('0 - b) : b;
    mag_q = mag_a / mag_b;
    mag_r = mag_a % mag_b;
    // the most negative value over minus one wraps back onto itself here
    q = (neg_a != neg_b) ? ('0 - mag_q) : mag_q;
    r = neg_a ? ('0 - mag_r) : mag_r;
    res.quot = sign_fill(q, w);
    res.rem  = sign_fill(r, w);
    return res;
  endfunction

  always @(posedge clk_i) begin
    quot_rem_t want;
    quot_rem_t got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_quot_rem_q.push_back(divide_truncating(sdq_op_e'(s_axis_tuser_i),
                                                        s_axis_tdata_i[DATA_W-1:0],
                                                        s_axis_tdata_i[2*DATA_W-1:DATA_W]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.quot = m_axis_tdata_i[DATA_W-1:0];
        got.rem  = m_axis_tdata_i[2*DATA_W-1:DATA_W];
        if (expected_quot_rem_q.size() == 0) begin
          $display("%0t: result with no division outstanding, expected none, got q=%h r=%h",
                   $time, got.quot, got.rem);
          n_errors++;
        end else begin
          want = expected_quot_rem_q.pop_front();
          if (got.quot !== want.quot) begin
            $display("%0t: quotient mismatch, expected %h, got %h", $time, want.quot,
                     got.quot);
            n_errors++;
          end
          if (got.rem !== want.rem) begin
            $display("%0t: remainder mismatch, expected %h, got %h", $time, want.rem,
                     got.rem);
            n_errors++;
          end
        end
      end
      n_waiting = expected_quot_rem_q.size();
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench import sdq_pkg::*;;

  localparam int unsigned WIDTH     = DEFAULT_WIDTH;
  localparam int          N_RANDOM  = 1450;
  localparam logic [63:0] MIN64     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64     = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MINUS_ONE = 64'hffff_ffff_ffff_ffff;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [2*DATA_W-1:0] s_axis_tdata_i = '0;
  logic                s_axis_tuser_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [2*DATA_W-1:0] m_axis_tdata_o;

  int err_cnt;
  int pending;

  int  n_sent = 0, n_narrow = 0, n_zero_div = 0, n_wrap = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  int  rx_stall = 0;
  int  rx_cycle = 0;

  always #1 clk_i = ~clk_i;

  signed_divider_quot_rem_top #(.WIDTH(WIDTH)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  signed_divider_quot_rem_checker #(.WIDTH(WIDTH)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending)
  );

  // mostly back to back, some short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_operand();
    int          r;
    logic [63:0] v;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: v = {$urandom, $urandom};
      4, 5: v = 64'($signed($urandom_range(0, 600)) - 300);
      6: begin
        case ($urandom_range(0, 8))
          0: v = '0;
          1: v = 64'd1;
          2: v = MINUS_ONE;
          3: v = MIN64;
          4: v = MAX64;
          5: v = 64'hffff_ffff_8000_0000;
          6: v = 64'h0000_0000_7fff_ffff;
          7: v = {$urandom, 32'h0};
          default: v = 64'd2;
        endcase
      end
      7, 8: v = {$urandom, $urandom} & 64'hffff_ffff;
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  task automatic send_division(input sdq_op_e op, input logic [63:0] dvd,
                               input logic [63:0] dvs, input int gap);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {dvs, dvd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_sent++;
    if (op == OP_DIV32) n_narrow++;
    if ((op == OP_DIV64) ? (dvs == '0) : (dvs[31:0] == '0)) n_zero_div++;
    if ((op == OP_DIV64) ? (dvd == MIN64 && dvs == MINUS_ONE)
                         : (dvd[31:0] == 32'h8000_0000 && dvs[31:0] == 32'hffff_ffff))
      n_wrap++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // result side backpressure, with calm stretches now and then
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 300 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (rx_stall != 0) begin
        rx_stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!rx_calm) rx_stall = pick_gap();
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** signed_divider_quot_rem_top: FAILED **");
    $finish;
  end

  initial begin
    sdq_op_e     op;
    logic [63:0] dvd, dvs;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // wide mode corners
    send_division(OP_DIV64, MIN64, MINUS_ONE, pick_gap());
    send_division(OP_DIV64, MIN64, 64'd1, pick_gap());
    send_division(OP_DIV64, MAX64, MINUS_ONE, pick_gap());
    send_division(OP_DIV64, MIN64, MIN64, pick_gap());
    send_division(OP_DIV64, MAX64, MIN64, pick_gap());
    send_division(OP_DIV64, MIN64, MAX64, pick_gap());
    send_division(OP_DIV64, 64'd7, -64'sd2, pick_gap());
    send_division(OP_DIV64, -64'sd7, 64'd2, pick_gap());
    send_division(OP_DIV64, -64'sd7, -64'sd2, pick_gap());
    send_division(OP_DIV64, 64'd7, 64'd2, pick_gap());
    send_division(OP_DIV64, 64'd0, 64'd5, pick_gap());
    send_division(OP_DIV64, 64'd5, 64'd0, pick_gap());
    send_division(OP_DIV64, MIN64, 64'd0, pick_gap());
    send_division(OP_DIV64, MINUS_ONE, MAX64, pick_gap());
    // narrow mode: upper operand bits are junk and must be ignored
    send_division(OP_DIV32, 64'h1234_5678_8000_0000, 64'h0000_0000_ffff_ffff, pick_gap());
    send_division(OP_DIV32, 64'h0000_0000_7fff_ffff, 64'hdead_beef_ffff_ffff, pick_gap());
    send_division(OP_DIV32, 64'hffff_ffff_ffff_fff9, 64'h5555_5555_0000_0002, pick_gap());
    send_division(OP_DIV32, 64'd100, 64'hffff_ffff_0000_0000, pick_gap());
    send_division(OP_DIV32, 64'haaaa_aaaa_0000_0064, 64'h0000_0000_ffff_fff9, pick_gap());
    send_division(OP_DIV32, 64'h0000_0000_8000_0000, 64'h0000_0000_8000_0000, pick_gap());
    send_division(OP_DIV32, 64'hffff_ffff_7fff_ffff, 64'h0000_0000_8000_0000, pick_gap());
    send_division(OP_DIV32, MINUS_ONE, 64'h0000_0000_8000_0000, pick_gap());
    send_division(OP_DIV32, 64'd0, 64'h8000_0000_0000_0000, pick_gap());

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      op = sdq_op_e'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 3) begin
        dvd = (op == OP_DIV64) ? MIN64 : {$urandom, 32'h8000_0000};
        dvs = (op == OP_DIV64) ? MINUS_ONE : {$urandom, 32'hffff_ffff};
      end else begin
        dvd = pick_operand();
        dvs = pick_operand();
      end
      send_division(op, dvd, dvs, tx_calm ? 0 : pick_gap());
    end
    s_axis_tvalid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (WIDTH + 8) @(posedge clk_i);

    $display("ran %0d divisions (%0d narrow, %0d wide) under random stalls on both sides",
             n_sent, n_narrow, n_sent - n_narrow);
    $display("of which %0d had a zero divisor and %0d wrapped most negative by minus one",
             n_zero_div, n_wrap);
    if (err_cnt == 0 && pending == 0) begin
      $display("** signed_divider_quot_rem_top: PASSED **");
    end else begin
      $display("** signed_divider_quot_rem_top: FAILED **");
    end
    $finish;
  end

endmodule
